>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPMP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpmp assertion failed");

// next-cycle implication
`define LPMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpmp assertion failed");

`endif

>>> hw/rtl/lpmp_pkg.sv
package lpmp_pkg;

	localparam int BACKOFF_MAX  = 5;
	localparam int BACKOFF_LAST = 5;

	localparam logic [1:0] FUNC_STEP   = 2'd0;
	localparam logic [1:0] FUNC_MANUAL = 2'd1;
	localparam logic [1:0] FUNC_BOOT   = 2'd2;

	localparam logic [2:0] ACT_NONE         = 3'd0;
	localparam logic [2:0] ACT_IDLE         = 3'd1;
	localparam logic [2:0] ACT_STOP_ABANDON = 3'd2;
	localparam logic [2:0] ACT_STOP         = 3'd3;
	localparam logic [2:0] ACT_MANUAL_SB    = 3'd4;
	localparam logic [2:0] ACT_AUTO_SB      = 3'd5;

	localparam logic [1:0] MODE_RUN     = 2'd0;
	localparam logic [1:0] MODE_STOP    = 2'd1;
	localparam logic [1:0] MODE_STANDBY = 2'd2;

	localparam logic [1:0] PS_THERMAL    = 2'd1;
	localparam logic [1:0] PS_SCREEN_OFF = 2'd2;

	localparam logic [1:0] CLKPOL_HIGH   = 2'd1;
	localparam logic [1:0] CLKPOL_MEDIUM = 2'd2;

	localparam logic [2:0] REG_ECO_POLICY     = 3'd0;
	localparam logic [2:0] REG_STANDBY_ENABLE = 3'd1;
	localparam logic [2:0] REG_CLOCK_POLICY   = 3'd2;
	localparam logic [2:0] REG_STOP_WAKE_MS   = 3'd3;
	localparam logic [2:0] REG_LOW_BATT_MV    = 3'd4;
	localparam logic [2:0] REG_RECOVER_MV     = 3'd5;
	localparam logic [2:0] REG_STANDBY_IDLE   = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PERIOD_W   = 21;

	localparam logic [PERIOD_W-1:0] MANUAL_WAKE_MS       = 21'd10000;
	localparam logic [15:0]         DEFAULT_STOP_WAKE_MS = 16'd1000;
	localparam logic [7:0]          RETRY_SAT            = 8'hFF;

	localparam logic [PERIOD_W-1:0] BACKOFF_TBL [6] = '{
		21'd60000, 21'd120000, 21'd300000, 21'd600000, 21'd900000, 21'd1800000
	};

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now_ms;
		logic [1:0]  power_state;
		logic        busy_locks;
		logic        stop_permitted;
		logic [15:0] batt_mv;
		logic        host_ack;
		logic        host_online;
		logic        woke_from_standby;
	} lpmp_req_t;

	typedef struct packed {
		logic [2:0]          action;
		logic [PERIOD_W-1:0] wake_ms;
		logic                clock_high;
		logic [1:0]          mode_state;
		logic [7:0]          retry_level;
	} lpmp_rsp_t;

	typedef struct packed {
		logic        eco_policy;
		logic        standby_enable;
		logic [1:0]  clock_policy;
		logic [15:0] stop_wake_ms;
		logic [15:0] low_batt_mv;
		logic [15:0] recover_batt_mv;
		logic [31:0] standby_idle_ms;
	} lpmp_cfg_t;

	typedef struct packed {
		logic [1:0]  last_ps;
		logic [31:0] scr_off_start;
		logic        host_prep;
		logic        manual_pend;
		logic [1:0]  mode;
		logic        ctx_valid;
		logic [7:0]  retry;
	} lpmp_state_t;

	localparam lpmp_cfg_t CFG_RESET = '{
		eco_policy:      1'b1,
		standby_enable:  1'b1,
		clock_policy:    2'd0,
		stop_wake_ms:    16'd1000,
		low_batt_mv:     16'd3000,
		recover_batt_mv: 16'd3300,
		standby_idle_ms: 32'd1800000
	};

	localparam lpmp_state_t STATE_RESET = '0;

	function automatic logic [PERIOD_W-1:0] backoff_period(input logic [7:0] retry);
		logic [7:0] lim;
		lim = retry;
		if (lim > 8'(BACKOFF_MAX)) lim = 8'(BACKOFF_MAX);
		if (lim > 8'(BACKOFF_LAST)) lim = 8'(BACKOFF_LAST);
		return BACKOFF_TBL[lim[2:0]];
	endfunction

endpackage

>>> hw/rtl/lpmp_decide.sv
module lpmp_decide import lpmp_pkg::*; (
	input  lpmp_cfg_t   cfg,
	input  lpmp_state_t st,
	input  lpmp_req_t   req,
	output lpmp_state_t st_nxt,
	output lpmp_rsp_t   res
);

	logic [31:0] elapsed;
	logic [7:0]  retry_inc;

	always_comb begin
		st_nxt  = st;
		res     = '0;
		elapsed = '0;
		retry_inc = (st.retry == RETRY_SAT) ? RETRY_SAT : st.retry + 8'd1;

		unique case (req.func)
			FUNC_STEP: begin
				if (req.power_state != st.last_ps) begin
					st_nxt.last_ps = req.power_state;
					if (req.power_state == PS_SCREEN_OFF) st_nxt.scr_off_start = req.now_ms;
					st_nxt.host_prep = 1'b0;
				end

				priority if (cfg.clock_policy == CLKPOL_HIGH) begin
					res.clock_high = 1'b1;
				end else if (cfg.clock_policy == CLKPOL_MEDIUM) begin
					res.clock_high = 1'b0;
				end else begin
					res.clock_high = req.busy_locks || (req.power_state == PS_THERMAL);
				end

				elapsed = req.now_ms - st_nxt.scr_off_start;

				priority if (st.manual_pend) begin
					st_nxt.manual_pend   = 1'b0;
					st_nxt.ctx_valid     = 1'b0;
					st_nxt.retry         = '0;
					st_nxt.mode          = MODE_STANDBY;
					res.action           = ACT_MANUAL_SB;
					res.wake_ms          = MANUAL_WAKE_MS;
				end else if (req.power_state != PS_SCREEN_OFF || !req.stop_permitted) begin
					st_nxt.mode = MODE_RUN;
					res.action  = ACT_IDLE;
				end else if (cfg.eco_policy && cfg.standby_enable &&
						elapsed >= cfg.standby_idle_ms &&
						req.batt_mv < cfg.low_batt_mv) begin
					st_nxt.ctx_valid   = 1'b1;
					st_nxt.retry       = '0;
					st_nxt.mode        = MODE_STANDBY;
					res.action         = ACT_AUTO_SB;
					res.wake_ms        = backoff_period(8'd0);
				end else if (!st_nxt.host_prep && !req.host_ack && req.host_online) begin
					st_nxt.mode = MODE_RUN;
					res.action  = ACT_STOP_ABANDON;
				end else begin
					st_nxt.host_prep   = 1'b1;
					st_nxt.mode        = MODE_STOP;
					res.action         = ACT_STOP;
					res.wake_ms        = (cfg.stop_wake_ms == '0) ?
						PERIOD_W'(DEFAULT_STOP_WAKE_MS) : PERIOD_W'(cfg.stop_wake_ms);
				end
			end
			FUNC_MANUAL: begin
				st_nxt.manual_pend = 1'b1;
			end
			FUNC_BOOT: begin
				if (req.woke_from_standby && st.ctx_valid) begin
					if (!cfg.standby_enable || !cfg.eco_policy ||
							req.batt_mv >= cfg.recover_batt_mv) begin
						st_nxt.ctx_valid = 1'b0;
						st_nxt.retry     = '0;
					end else begin
						st_nxt.ctx_valid   = 1'b1;
						st_nxt.retry       = retry_inc;
						st_nxt.mode        = MODE_STANDBY;
						res.action         = ACT_AUTO_SB;
						res.wake_ms        = backoff_period(retry_inc);
					end
				end
			end
			default: begin
			end
		endcase

		res.mode_state  = st_nxt.mode;
		res.retry_level = st_nxt.retry;
	end

endmodule

>>> hw/rtl/low_power_mode_policy.sv
// channel  dir  payload     handshake
// req      in   lpmp_req_t  req_valid / req_stall
// rsp      out  lpmp_rsp_t  rsp_valid / rsp_stall
// cfg      in   index+data  cfg_we, no wait
//
// one item per cycle sustained while rsp_stall is low
// the decision is one pass of logic between the request register and the
// response register, state is written as the item leaves the request register
// reset (arst_n low) at once clears state and valid flags, presets config
// a stalled response holds the request register, which then stalls req
`include "assert_macros.svh"

module low_power_mode_policy import lpmp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  lpmp_req_t             req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output lpmp_rsp_t             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lpmp_cfg_t   cfg_q;
	lpmp_state_t st_q;
	lpmp_state_t st_nxt;
	lpmp_req_t   req_s1;
	logic        valid_s1;
	lpmp_rsp_t   res;
	lpmp_rsp_t   rsp_q;
	logic        rsp_valid_q;
	logic        adv;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lpmp_decide u_decide (
		.cfg    (cfg_q),
		.st     (st_q),
		.req    (req_s1),
		.st_nxt (st_nxt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ECO_POLICY:     cfg_q.eco_policy      <= cfg_data[0];
				REG_STANDBY_ENABLE: cfg_q.standby_enable  <= cfg_data[0];
				REG_CLOCK_POLICY:   cfg_q.clock_policy    <= cfg_data[1:0];
				REG_STOP_WAKE_MS:   cfg_q.stop_wake_ms    <= cfg_data[15:0];
				REG_LOW_BATT_MV:    cfg_q.low_batt_mv     <= cfg_data[15:0];
				REG_RECOVER_MV:     cfg_q.recover_batt_mv <= cfg_data[15:0];
				REG_STANDBY_IDLE:   cfg_q.standby_idle_ms <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			st_q        <= STATE_RESET;
		end else begin
			if (!req_stall) valid_s1 <= req_valid;
			if (adv) begin
				rsp_valid_q <= valid_s1;
				if (valid_s1) st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall) req_s1 <= req;
		if (adv && valid_s1) rsp_q <= res;
	end

	`LPMP_ASSERT_IMP(a_stop_mode, rsp_valid && rsp.action == ACT_STOP, rsp.mode_state == MODE_STOP && rsp.wake_ms != '0)
	`LPMP_ASSERT_IMP(a_idle_run, rsp_valid && (rsp.action == ACT_IDLE || rsp.action == ACT_STOP_ABANDON), rsp.mode_state == MODE_RUN && rsp.wake_ms == '0)
	`LPMP_ASSERT_IMP(a_retry_ctx, st_q.retry != '0, st_q.ctx_valid)
	`LPMP_ASSERT_NEXT(a_beat_moves, valid_s1 && !req_stall, rsp_valid)

endmodule
